[sv/bdrw_pkg.sv]
// ---------------------------------------------------------------------------
// bdrw_pkg
// Shared widths, register indexes and codes of the binary dilation block.
// ---------------------------------------------------------------------------
`default_nettype none

package bdrw_pkg;

  // field widths of the channels
  localparam int OPCODE_W   = 1;
  localparam int PIXEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ELEM_W     = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_ELEMENT_HEIGHT = 2'd2,
    REG_ELEMENT_WIDTH  = 2'd3
  } cfg_reg_t;

  // input item codes
  localparam logic [OPCODE_W-1:0] OP_PIXEL = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_DRAIN = 1'b1;

  // register values after reset
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
  localparam logic [ELEM_W-1:0]     RST_ELEMENT_HEIGHT = 4'd3;
  localparam logic [ELEM_W-1:0]     RST_ELEMENT_WIDTH  = 4'd3;

  // result queue depth
  localparam int OFIFO_DEPTH = 4;

endpackage

`default_nettype wire

[sv/bdrw_if.sv]
// ---------------------------------------------------------------------------
// bdrw channel interfaces
// Valid/ready channels for pixels in, dilated results out and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

// pixel stream
interface bdrw_in_if;
  import bdrw_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PIXEL_W-1:0]  pixel;
  modport source (output valid, opcode, pixel, input ready);
  modport sink   (input valid, opcode, pixel, output ready);
endinterface

// dilated result stream
interface bdrw_out_if;
  logic valid;
  logic ready;
  logic dilated;
  logic frame_last;
  modport source (output valid, dilated, frame_last, input ready);
  modport sink   (input valid, dilated, frame_last, output ready);
endinterface

// register write channel
interface bdrw_cfg_if;
  import bdrw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/binary_dilation_rect_window_top.sv]
// ---------------------------------------------------------------------------
// binary_dilation_rect_window_top
// Raster-order binary dilation with a rectangular window: per-column row
// history in one memory (read, shift in new bit, write back), vertical OR
// per column, then a horizontal OR over a short line of column results.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                  | transfer when
//  ---------+-----+--------------------------+---------------------------
//  in_if    | in  | opcode, pixel            | in_if.valid & in_if.ready
//  out_if   | out | dilated, frame_last      | out_if.valid & out_if.ready
//  cfg_if   | in  | index, data              | cfg_if.valid & cfg_if.ready
//
//  One pixel per clock while in_ready is high; a result is visible once
//  stage 1 has written it to the result queue. The column history memory
//  port (read at accept, write back from stage 1, same-column hazard
//  forwarded) sets that pace. in_ready is held low after reset and after
//  each register write while the derived window sizes settle; cfg_ready
//  is always high. A four-entry result queue absorbs output stalls;
//  in_ready drops once the queue plus the item in flight would fill it.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_dilation_rect_window_top #(
  parameter int MAX_IMAGE_WIDTH  = 1024,
  parameter int MAX_IMAGE_HEIGHT = 1024,
  parameter int MAX_ELEMENT_SIZE = 15
) (
  input  wire         clk,
  input  wire         rst_n,
  bdrw_in_if.sink     in_if,
  bdrw_out_if.source  out_if,
  bdrw_cfg_if.sink    cfg_if
);

  import bdrw_pkg::*;

  localparam int HALF_MAX = MAX_ELEMENT_SIZE / 2;
  localparam int WIN      = 2 * HALF_MAX + 1;
  localparam int HALF_W   = (HALF_MAX < 1) ? 1 : $clog2(HALF_MAX + 1);
  localparam int COL_W    = $clog2(MAX_IMAGE_WIDTH);
  localparam int WID_W    = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int HGT_W    = $clog2(MAX_IMAGE_HEIGHT + 1);
  localparam int CNT_W    = $clog2(MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT
                                   + HALF_MAX * MAX_IMAGE_WIDTH + HALF_MAX + 1);
  localparam int RS_W     = (WIN < 2) ? 1 : $clog2(WIN);
  localparam int SR_W     = (WIN < 2) ? 1 : WIN - 1;
  localparam int SUM_W    = ((WID_W > HALF_W + 1) ? WID_W : HALF_W + 1) + 2;
  localparam int FP_W     = $clog2(OFIFO_DEPTH);

  typedef struct packed {
    logic dilated;
    logic frame_last;
  } out_item_t;

  // configuration registers
  logic [CFG_DATA_W-1:0] img_w_r, img_h_r;
  logic [ELEM_W-1:0]     elem_h_r, elem_w_r;
  logic                  settle_r;

  // derived window geometry
  logic [WID_W-1:0]  w_c, w_r;
  logic [HGT_W-1:0]  h_c;
  logic [HALF_W-1:0] hh_c, hw_c, hh_r, hw_r;
  logic [COL_W-1:0]  wm1_r;
  logic [CNT_W-1:0]  total_r, delay_r;

  // stream position counters
  logic [CNT_W-1:0] n_r, k_r;
  logic [COL_W-1:0] col_r, c_r;
  logic [RS_W-1:0]  row_sat_r;

  // stage 0 decode
  logic             acc, cfg_acc;
  logic             bit0, emit0, last0;
  logic [WIN-1:0]   vmask0, hmask0;
  logic [SUM_W-1:0] hsum;

  // stage 1 registers
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_bit_r, s1_emit_r, s1_last_r;
  logic [WIN-1:0]   s1_vmask_r, s1_hmask_r;
  logic             fwd_r;
  logic [WIN-1:0]   wb_r, rdata_r;
  logic [SR_W-1:0]  sr_r;

  // column history memory
  logic [WIN-1:0] hist_mem [MAX_IMAGE_WIDTH];

  // stage 1 datapath
  logic [WIN-1:0] hist, newv, taps;
  logic           vbit, win_or;

  // result queue
  out_item_t       fifo_r [OFIFO_DEPTH];
  logic [FP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FP_W:0]   cnt_r;
  logic            push, pop;

  assign acc     = in_if.valid & in_if.ready;
  assign cfg_acc = cfg_if.valid & cfg_if.ready;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !settle_r &&
                        ((cnt_r + (FP_W + 1)'(s1_valid_r)) < (FP_W + 1)'(OFIFO_DEPTH));

  // clamp register values into the supported range
  always_comb begin
    if (img_w_r == '0) begin
      w_c = WID_W'(1);
    end else if (32'(img_w_r) > MAX_IMAGE_WIDTH) begin
      w_c = WID_W'(MAX_IMAGE_WIDTH);
    end else begin
      w_c = WID_W'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_c = HGT_W'(1);
    end else if (32'(img_h_r) > MAX_IMAGE_HEIGHT) begin
      h_c = HGT_W'(MAX_IMAGE_HEIGHT);
    end else begin
      h_c = HGT_W'(img_h_r);
    end
    hh_c = (32'(elem_h_r) > MAX_ELEMENT_SIZE) ? HALF_W'(HALF_MAX) : HALF_W'(elem_h_r >> 1);
    hw_c = (32'(elem_w_r) > MAX_ELEMENT_SIZE) ? HALF_W'(HALF_MAX) : HALF_W'(elem_w_r >> 1);
  end

  // geometry registers, refreshed every cycle
  always_ff @(posedge clk) begin
    w_r     <= w_c;
    wm1_r   <= COL_W'(w_c - WID_W'(1));
    hh_r    <= hh_c;
    hw_r    <= hw_c;
    total_r <= CNT_W'(w_c) * CNT_W'(h_c);
    delay_r <= CNT_W'(hh_c) * CNT_W'(w_c) + CNT_W'(hw_c);
  end

  // per-item decode at the input transfer
  always_comb begin
    bit0  = (in_if.opcode == OP_PIXEL) && (n_r < total_r) && (in_if.pixel != '0);
    emit0 = n_r >= delay_r;
    last0 = emit0 && (k_r == total_r - CNT_W'(1));
    hsum  = SUM_W'(hw_r) + SUM_W'(c_r) + SUM_W'(1);
    for (int i = 0; i < WIN; i++) begin
      vmask0[i] = (i <= 2 * int'(hh_r)) && (i <= int'(row_sat_r));
      hmask0[i] = (SUM_W'(i) < hsum) && ((SUM_W'(i) + SUM_W'(w_r)) >= hsum) &&
                  (i <= 2 * int'(hw_r));
    end
  end

  // registers and stream counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= RST_IMAGE_WIDTH;
      img_h_r   <= RST_IMAGE_HEIGHT;
      elem_h_r  <= RST_ELEMENT_HEIGHT;
      elem_w_r  <= RST_ELEMENT_WIDTH;
      settle_r  <= 1'b1;
      n_r       <= '0;
      k_r       <= '0;
      col_r     <= '0;
      c_r       <= '0;
      row_sat_r <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_IMAGE_WIDTH:    img_w_r  <= cfg_if.data;
        REG_IMAGE_HEIGHT:   img_h_r  <= cfg_if.data;
        REG_ELEMENT_HEIGHT: elem_h_r <= cfg_if.data[ELEM_W-1:0];
        REG_ELEMENT_WIDTH:  elem_w_r <= cfg_if.data[ELEM_W-1:0];
      endcase
      settle_r  <= 1'b1;
      n_r       <= '0;
      k_r       <= '0;
      col_r     <= '0;
      c_r       <= '0;
      row_sat_r <= '0;
    end else begin
      settle_r <= 1'b0;
      if (acc) begin
        if (last0) begin
          n_r       <= '0;
          k_r       <= '0;
          col_r     <= '0;
          c_r       <= '0;
          row_sat_r <= '0;
        end else begin
          n_r <= n_r + CNT_W'(1);
          if (col_r == wm1_r) begin
            col_r <= '0;
            if (row_sat_r != RS_W'(WIN - 1)) begin
              row_sat_r <= row_sat_r + RS_W'(1);
            end
          end else begin
            col_r <= col_r + COL_W'(1);
          end
          if (emit0) begin
            k_r <= k_r + CNT_W'(1);
            c_r <= (c_r == wm1_r) ? '0 : c_r + COL_W'(1);
          end
        end
      end
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
  end

  // stage 1 payload, history read and same-column forward flag
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r   <= col_r;
      s1_bit_r   <= bit0;
      s1_emit_r  <= emit0;
      s1_last_r  <= last0;
      s1_vmask_r <= vmask0;
      s1_hmask_r <= hmask0;
      fwd_r      <= s1_valid_r && (s1_col_r == col_r);
      rdata_r    <= hist_mem[col_r];
    end
  end

  // shift new row bit into the column history, vertical and horizontal OR
  always_comb begin
    hist   = fwd_r ? wb_r : rdata_r;
    newv   = WIN'({hist, s1_bit_r});
    vbit   = |(newv & s1_vmask_r);
    taps   = WIN'({sr_r, vbit});
    win_or = |(taps & s1_hmask_r);
  end

  // history write back and column result line
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      hist_mem[s1_col_r] <= newv;
      wb_r               <= newv;
      sr_r               <= SR_W'({sr_r, vbit});
    end
  end

  // result queue
  assign push = s1_valid_r & s1_emit_r;
  assign pop  = out_if.valid & out_if.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{dilated: win_or, frame_last: s1_last_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FP_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FP_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (FP_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (FP_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_if.valid      = cnt_r != '0;
  assign out_if.dilated    = fifo_r[rd_ptr_r].dilated;
  assign out_if.frame_last = fifo_r[rd_ptr_r].frame_last;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangular-window binary dilation block.
// Pixels and drain steps go in over a valid/ready stream. A predictor keeps
// its own copy of the registers, the per-column row history and the stream
// position, and queues the expected result for each input transfer past
// the window delay. A checker compares each output transfer against the
// oldest expected result. Directed cases, register extremes and randomized
// frames run in turn, with random idling on both sides of the stream.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdrw_pkg::*;

  localparam int MAX_W     = 1024;
  localparam int MAX_H     = 1024;
  localparam int MAX_ELEM  = 15;
  localparam int SETTLE    = 8;
  localparam int RAND_ITEMS = 300;

  typedef struct packed {
    logic dilated;
    logic frame_last;
  } dilation_result_t;

  logic clk;
  logic rst_n;

  bdrw_in_if  in_ch ();
  bdrw_out_if out_ch ();
  bdrw_cfg_if cfg_ch ();

  binary_dilation_rect_window_top #(
    .MAX_IMAGE_WIDTH  (MAX_W),
    .MAX_IMAGE_HEIGHT (MAX_H),
    .MAX_ELEMENT_SIZE (MAX_ELEM)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state
  logic [CFG_DATA_W-1:0] img_w;
  logic [CFG_DATA_W-1:0] img_h;
  logic [ELEM_W-1:0]     elem_h;
  logic [ELEM_W-1:0]     elem_w;
  bit   [31:0]           col_rows [MAX_W];
  int                    stream_pos;

  dilation_result_t expected_pixels [$];

  // knobs and bookkeeping
  int in_idle_pct   = 31;
  int out_stall_pct = 31;
  int items_sent    = 0;
  int results_seen  = 0;
  int frames_seen   = 0;
  int reg_writes    = 0;
  int error_count   = 0;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // effective sizes after saturation
  function automatic int eff_width();
    return (img_w == 0) ? 1 : ((img_w > MAX_W) ? MAX_W : int'(img_w));
  endfunction

  function automatic int eff_height();
    return (img_h == 0) ? 1 : ((img_h > MAX_H) ? MAX_H : int'(img_h));
  endfunction

  function automatic int frame_total();
    return eff_width() * eff_height();
  endfunction

  function automatic int frame_delay();
    return (int'(elem_h) / 2) * eff_width() + int'(elem_w) / 2;
  endfunction

  // register write as seen by the predictor: any write restarts the frame
  function automatic void apply_reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w = data;
      end
      REG_IMAGE_HEIGHT: begin
        img_h = data;
      end
      REG_ELEMENT_HEIGHT: begin
        elem_h = data[ELEM_W-1:0];
      end
      REG_ELEMENT_WIDTH: begin
        elem_w = data[ELEM_W-1:0];
      end
      default: begin
      end
    endcase
    stream_pos = 0;
  endfunction

  // shift the new bit into its column, then OR the window of the output due now
  function automatic void predict_dilation(logic [OPCODE_W-1:0] op, logic [PIXEL_W-1:0] pix);
    int w, h, hh, hw, total, delay, n, k;
    int cur_row, cur_col, r, c, lo, hi, xlo, xhi, newest, row;
    bit in_bit;
    bit hit;
    bit [31:0] hist;
    dilation_result_t res;
    w = eff_width();
    h = eff_height();
    hh = int'(elem_h) / 2;
    hw = int'(elem_w) / 2;
    total = w * h;
    delay = hh * w + hw;
    n = stream_pos;
    in_bit = (op == OP_PIXEL) && (n < total) && (pix != 0);
    cur_row = n / w;
    cur_col = n % w;
    col_rows[cur_col] = {col_rows[cur_col][30:0], in_bit};
    stream_pos = n + 1;
    if (n < delay) return;

    k = n - delay;
    r = k / w;
    c = k % w;
    lo = (r - hh < 0) ? 0 : r - hh;
    hi = (r + hh > h - 1) ? h - 1 : r + hh;
    xlo = (c - hw < 0) ? 0 : c - hw;
    xhi = (c + hw > w - 1) ? w - 1 : c + hw;
    hit = 1'b0;
    for (int x = xlo; x <= xhi; x++) begin
      newest = (x <= cur_col) ? cur_row : cur_row - 1;
      hist = col_rows[x];
      for (int i = 0; i < 32; i++) begin
        row = newest - i;
        if (row < lo) break;
        if (row <= hi && hist[i]) hit = 1'b1;
      end
    end
    res.dilated = hit;
    res.frame_last = (k + 1 >= total);
    if (res.frame_last) stream_pos = 0;
    expected_pixels.push_back(res);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel(int density);
    return ($urandom_range(99) < density) ? PIXEL_W'($urandom_range(1, 255)) : '0;
  endfunction

  // one input transfer, with random idle cycles in front
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [PIXEL_W-1:0] pix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.pixel  <= pix;
    do @(posedge clk); while (!in_ch.ready);
    predict_dilation(op, pix);
    items_sent++;
  endtask

  // stop sending and let every expected result come out
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes on an idle block; bit i of sel writes register i
  task automatic set_config(bit [3:0] sel, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                            logic [CFG_DATA_W-1:0] eh, logic [CFG_DATA_W-1:0] ew);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[0] = w;
    vals[1] = h;
    vals[2] = eh;
    vals[3] = ew;
    wait_quiet();
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= cfg_reg_t'(i);
        cfg_ch.data  <= vals[i];
        do @(posedge clk); while (!cfg_ch.ready);
        apply_reg_write(cfg_reg_t'(i), vals[i]);
        reg_writes++;
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // finish the current frame from wherever the stream stands
  task automatic run_frame(int density, int noise_pct);
    do begin
      if (stream_pos < frame_total()) begin
        if ($urandom_range(99) < noise_pct) send_item(OP_DRAIN, PIXEL_W'($urandom));
        else send_item(OP_PIXEL, rand_pixel(density));
      end else begin
        if ($urandom_range(99) < noise_pct) send_item(OP_PIXEL, PIXEL_W'($urandom));
        else send_item(OP_DRAIN, PIXEL_W'($urandom));
      end
    end while (stream_pos != 0);
  endtask

  // result stall pattern
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    dilation_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.frame_last) frames_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result expected none actual dilated=%0b frame_last=%0b",
                 $time, out_ch.dilated, out_ch.frame_last);
        error_count++;
      end else begin
        exp_res = expected_pixels.pop_front();
        if (out_ch.dilated !== exp_res.dilated) begin
          $display("%0t: dilated mismatch expected %0b actual %0b",
                   $time, exp_res.dilated, out_ch.dilated);
          error_count++;
        end
        if (out_ch.frame_last !== exp_res.frame_last) begin
          $display("%0t: frame_last mismatch expected %0b actual %0b",
                   $time, exp_res.frame_last, out_ch.frame_last);
          error_count++;
        end
      end
    end
  end

  // power-on registers: the window is far away, so no result may appear
  task automatic test_power_on_defaults();
    for (int i = 0; i < 16; i++) send_item(OP_PIXEL, rand_pixel(50));
    wait_quiet();
  endtask

  // small 3x2 image, even element width widening to three columns
  task automatic test_directed_stream();
    set_config(4'hF, 11'd3, 11'd2, 11'd3, 11'd2);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_PIXEL, 8'h01);
    send_item(OP_PIXEL, 8'h80);
    send_item(OP_PIXEL, 8'h00);
    // pixel past the frame end acts as a drain
    send_item(OP_PIXEL, 8'h4D);
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_DRAIN, 8'h00);
    // drain after the last output opens the next frame as a zero pixel
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h40);
    for (int i = 0; i < 4; i++) send_item(OP_DRAIN, 8'hAA);
    wait_quiet();
  endtask

  // zero sizes act as one, oversized values saturate
  task automatic test_register_limits();
    set_config(4'hF, 11'd0, 11'd0, 11'd0, 11'd0);
    send_item(OP_PIXEL, 8'h05);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_PIXEL, 8'hFF);
    // widest row, single line, widest element horizontally; start of the row only
    set_config(4'hF, 11'h7FF, 11'd1, 11'h7F0, 11'h7FF);
    for (int i = 0; i < 24; i++) send_item(OP_PIXEL, rand_pixel(10));
    // tallest image, one column, largest element both ways; top rows only
    set_config(4'hF, 11'd1, 11'h7FF, 11'd15, 11'd15);
    for (int i = 0; i < 40; i++) send_item(OP_PIXEL, rand_pixel(10));
    set_config(4'hF, 11'd2, 11'd1, 11'd15, 11'd1);
    run_frame(50, 10);
  endtask

  // a register write in the middle of a frame starts a new frame
  task automatic test_frame_restart();
    set_config(4'hF, 11'd4, 11'd3, 11'd3, 11'd3);
    for (int i = 0; i < 7; i++) send_item(OP_PIXEL, rand_pixel(40));
    set_config(4'b0100, 11'd0, 11'd0, 11'd5, 11'd0);
    run_frame(20, 5);
  endtask

  // random sizes and frames, some frames cut short or left hanging
  task automatic test_random_frames();
    int start_items, done, len, density, quiet_start;
    logic [CFG_DATA_W-1:0] w, h, eh, ew;
    start_items = items_sent;
    done = 0;
    quiet_start = -1;
    while (done < RAND_ITEMS) begin
      // quiet stretch without idling on either side
      if (quiet_start < 0 && done >= 150) quiet_start = done;
      if (quiet_start >= 0 && done < quiet_start + 110) begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct = 31;
        out_stall_pct = 31;
      end
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(99) < 4) w = 11'd0;
        else if ($urandom_range(99) < 12) w = CFG_DATA_W'($urandom_range(9, 48));
        else w = CFG_DATA_W'($urandom_range(1, 8));
        if ($urandom_range(99) < 4) h = 11'd0;
        else h = CFG_DATA_W'($urandom_range(1, 6));
        eh = ($urandom_range(99) < 25) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 15));
        ew = ($urandom_range(99) < 25) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 15));
        set_config(4'($urandom_range(1, 15)), w, h, eh, ew);
      end
      density = $urandom_range(2, 45);
      if ($urandom_range(99) < 85) begin
        run_frame(density, 6);
      end else begin
        len = $urandom_range(1, frame_total() + frame_delay());
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(1)) send_item(OP_DRAIN, PIXEL_W'($urandom));
          else send_item(OP_PIXEL, rand_pixel(density));
        end
      end
      done = items_sent - start_items;
    end
    in_idle_pct = 31;
    out_stall_pct = 31;
    wait_quiet();
  endtask

  // main sequence
  initial begin
    img_w  = RST_IMAGE_WIDTH;
    img_h  = RST_IMAGE_HEIGHT;
    elem_h = RST_ELEMENT_HEIGHT;
    elem_w = RST_ELEMENT_WIDTH;
    stream_pos = 0;
    foreach (col_rows[i]) col_rows[i] = '0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_PIXEL;
    in_ch.pixel  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_WIDTH;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_directed_stream();
    test_register_limits();
    test_frame_restart();
    test_random_frames();

    wait_quiet();
    $display("run covered %0d input transfers, %0d results in %0d frames, %0d register writes",
             items_sent, results_seen, frames_seen, reg_writes);
    $display("window sizes 1x1 to 15x15, image rows 1 to 1024 wide and tall, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
